FILE: rtl/core/pct_pkg.sv
// shared types and constants for the polyline crossing trim block
package pct_pkg;

   localparam logic [1:0] OpLeft  = 2'd0;
   localparam logic [1:0] OpRight = 2'd1;
   localparam logic [1:0] OpEval  = 2'd2;

   localparam logic [2:0] LastStep = 3'd7;

   typedef struct packed {
      logic done;
      logic hit;
   } pct_unit_rsp_type;

endpackage

FILE: rtl/core/polyline_crossing_trim.sv
// top level of the polyline crossing trim block
// Append requests (left or right point) are taken while idle; a point beyond
// MAX_POINTS is dropped and reported as overflow on the next evaluate. An
// evaluate request walks every left segment against every right segment,
// each pair passing through the read states RD_FIRST, RD_SECOND and LOAD,
// which fetch its four points from the point memories, and then through the
// shared multiplier unit, which forms the eight cross products of the four
// orientation tests one after another. When either side holds fewer than two
// points, the evaluate skips the pair walk and goes straight to its result.
// Requests stall while an evaluate runs; the result sits in an output
// register, so the next request is taken while it waits. After the result
// both polylines are empty and the overflow flag is clear.
module polyline_crossing_trim
   import pct_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 16,
   localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_opcode,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [CNT_W-1:0]             rsp_left_keep,
   output logic [CNT_W-1:0]             rsp_right_keep,
   output logic                         rsp_crossed,
   output logic                         rsp_overflow
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int PT_W  = 2 * COORD_BITS;

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_RD_FIRST  = 6'b000010,
      ST_RD_SECOND = 6'b000100,
      ST_LOAD      = 6'b001000,
      ST_RUN       = 6'b010000,
      ST_FINISH    = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  left_count_ff, left_count_in;
   logic [CNT_W-1:0]  right_count_ff, right_count_in;
   logic              dropped_ff, dropped_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]  lkeep_ff, lkeep_in;
   logic [CNT_W-1:0]  rkeep_ff, rkeep_in;
   logic              hit_ff, hit_in;
   logic [PT_W-1:0]   a_ff, a_in;
   logic [PT_W-1:0]   b_ff, b_in;
   logic [PT_W-1:0]   c_ff, c_in;
   logic [PT_W-1:0]   d_ff, d_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  rsp_left_keep_ff, rsp_left_keep_in;
   logic [CNT_W-1:0]  rsp_right_keep_ff, rsp_right_keep_in;
   logic              rsp_crossed_ff, rsp_crossed_in;
   logic              rsp_overflow_ff, rsp_overflow_in;

   logic [PT_W-1:0]   left_mem_ff [MAX_POINTS];
   logic [PT_W-1:0]   right_mem_ff [MAX_POINTS];
   logic [PT_W-1:0]   left_rd_ff;
   logic [PT_W-1:0]   right_rd_ff;

   logic              req_accept;
   logic              left_we, right_we;
   logic [PT_W-1:0]   wdata;
   logic [IDX_W-1:0]  left_raddr, right_raddr;
   logic [CNT_W-1:0]  i_plus, j_plus;
   logic              last_i, last_j;
   logic              unit_start;
   pct_unit_rsp_type  unit_rsp;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign wdata      = {req_coord_x, req_coord_y};

   assign left_we  = req_accept && (req_opcode == OpLeft) &&
                     (left_count_ff < CNT_W'(MAX_POINTS));
   assign right_we = req_accept && (req_opcode == OpRight) &&
                     (right_count_ff < CNT_W'(MAX_POINTS));

   // first read of a pair fetches segment starts, the second the segment ends
   assign left_raddr  = (state_ff == ST_RD_FIRST) ? i_ff : i_ff + IDX_W'(1);
   assign right_raddr = (state_ff == ST_RD_FIRST) ? j_ff : j_ff + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (left_we) begin
         left_mem_ff[left_count_ff[IDX_W-1:0]] <= wdata;
      end
      left_rd_ff <= left_mem_ff[left_raddr];
   end

   always_ff @(posedge clock) begin
      if (right_we) begin
         right_mem_ff[right_count_ff[IDX_W-1:0]] <= wdata;
      end
      right_rd_ff <= right_mem_ff[right_raddr];
   end

   assign i_plus = CNT_W'(i_ff) + CNT_W'(1);
   assign j_plus = CNT_W'(j_ff) + CNT_W'(1);
   assign last_i = (CNT_W'(i_ff) + CNT_W'(2)) >= left_count_ff;
   assign last_j = (CNT_W'(j_ff) + CNT_W'(2)) >= right_count_ff;

   always_comb begin
      state_in          = state_ff;
      left_count_in     = left_count_ff;
      right_count_in    = right_count_ff;
      dropped_in        = dropped_ff;
      i_in              = i_ff;
      j_in              = j_ff;
      lkeep_in          = lkeep_ff;
      rkeep_in          = rkeep_ff;
      hit_in            = hit_ff;
      a_in              = a_ff;
      b_in              = b_ff;
      c_in              = c_ff;
      d_in              = d_ff;
      unit_start        = 1'b0;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_left_keep_in  = rsp_left_keep_ff;
      rsp_right_keep_in = rsp_right_keep_ff;
      rsp_crossed_in    = rsp_crossed_ff;
      rsp_overflow_in   = rsp_overflow_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_opcode)
                  OpLeft: begin
                     if (left_we) begin
                        left_count_in = left_count_ff + CNT_W'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  OpRight: begin
                     if (right_we) begin
                        right_count_in = right_count_ff + CNT_W'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  OpEval: begin
                     lkeep_in = left_count_ff;
                     rkeep_in = right_count_ff;
                     hit_in   = 1'b0;
                     i_in     = '0;
                     j_in     = '0;
                     if ((left_count_ff >= CNT_W'(2)) && (right_count_ff >= CNT_W'(2))) begin
                        state_in = ST_RD_FIRST;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RD_FIRST: begin
            state_in = ST_RD_SECOND;
         end
         ST_RD_SECOND: begin
            a_in     = left_rd_ff;
            c_in     = right_rd_ff;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            b_in       = left_rd_ff;
            d_in       = right_rd_ff;
            unit_start = 1'b1;
            state_in   = ST_RUN;
         end
         ST_RUN: begin
            if (unit_rsp.done) begin
               if (unit_rsp.hit) begin
                  hit_in = 1'b1;
                  if (i_plus < lkeep_ff) begin
                     lkeep_in = i_plus;
                  end
                  if (j_plus < rkeep_ff) begin
                     rkeep_in = j_plus;
                  end
               end
               if (!last_j) begin
                  j_in     = j_ff + IDX_W'(1);
                  state_in = ST_RD_FIRST;
               end else if (!last_i) begin
                  i_in     = i_ff + IDX_W'(1);
                  j_in     = '0;
                  state_in = ST_RD_FIRST;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_left_keep_in  = lkeep_ff;
               rsp_right_keep_in = rkeep_ff;
               rsp_crossed_in    = hit_ff;
               rsp_overflow_in   = dropped_ff;
               left_count_in     = '0;
               right_count_in    = '0;
               dropped_in        = 1'b0;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         left_count_ff  <= '0;
         right_count_ff <= '0;
         dropped_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         left_count_ff  <= left_count_in;
         right_count_ff <= right_count_in;
         dropped_ff     <= dropped_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff              <= i_in;
      j_ff              <= j_in;
      lkeep_ff          <= lkeep_in;
      rkeep_ff          <= rkeep_in;
      hit_ff            <= hit_in;
      a_ff              <= a_in;
      b_ff              <= b_in;
      c_ff              <= c_in;
      d_ff              <= d_in;
      rsp_left_keep_ff  <= rsp_left_keep_in;
      rsp_right_keep_ff <= rsp_right_keep_in;
      rsp_crossed_ff    <= rsp_crossed_in;
      rsp_overflow_ff   <= rsp_overflow_in;
   end

   pct_cross_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_cross (
      .clock    (clock),
      .reset    (reset),
      .start    (unit_start),
      .pt_a     (a_ff),
      .pt_b     (b_ff),
      .pt_c     (c_ff),
      .pt_d     (d_ff),
      .unit_rsp (unit_rsp)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_left_keep  = rsp_left_keep_ff;
   assign rsp_right_keep = rsp_right_keep_ff;
   assign rsp_crossed    = rsp_crossed_ff;
   assign rsp_overflow   = rsp_overflow_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      unit_rsp.done |-> state_ff == ST_RUN)
      else $error("unit finished outside run state");

   a_run_has_segments: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> (left_count_ff >= CNT_W'(2)) && (right_count_ff >= CNT_W'(2)))
      else $error("pair test without two segments");

   a_keep_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_left_keep_ff <= CNT_W'(MAX_POINTS)) &&
                       (rsp_right_keep_ff <= CNT_W'(MAX_POINTS)))
      else $error("keep length beyond capacity");

endmodule

FILE: rtl/core/pct_cross_unit.sv
// shared multiplier unit that runs the four orientation tests of one segment pair
module pct_cross_unit
   import pct_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [2*COORD_BITS-1:0]   pt_a,
   input  logic [2*COORD_BITS-1:0]   pt_b,
   input  logic [2*COORD_BITS-1:0]   pt_c,
   input  logic [2*COORD_BITS-1:0]   pt_d,
   output pct_unit_rsp_type          unit_rsp
);

   localparam int PT_W = 2 * COORD_BITS;
   localparam int DW   = COORD_BITS + 1;
   localparam int PW   = 2 * DW;
   localparam int EW   = PW + 1;

   logic                   busy_ff, busy_in;
   logic [2:0]             step_ff, step_in;
   logic                   s1_vld_ff;
   logic [2:0]             s1_step_ff;
   logic signed [DW-1:0]   da_ff, da_in;
   logic signed [DW-1:0]   db_ff, db_in;
   logic                   s2_vld_ff;
   logic [2:0]             s2_step_ff;
   logic signed [PW-1:0]   prod_ff, prod_in;
   logic signed [PW-1:0]   first_ff;
   logic [3:0]             pos_ff;
   logic [3:0]             neg_ff;
   logic                   done_ff;

   logic [PT_W-1:0]        sel_p, sel_q, sel_r;
   logic signed [COORD_BITS-1:0] p_x, p_y, q_x, q_y, r_x, r_y;
   logic signed [EW-1:0]   cmp_diff;
   logic                   cmp_pos, cmp_neg;

   // operand points of the orientation test selected by the step
   always_comb begin
      unique case (step_ff[2:1])
         2'd0: begin
            sel_p = pt_a; sel_q = pt_b; sel_r = pt_c;
         end
         2'd1: begin
            sel_p = pt_a; sel_q = pt_b; sel_r = pt_d;
         end
         2'd2: begin
            sel_p = pt_c; sel_q = pt_d; sel_r = pt_a;
         end
         default: begin
            sel_p = pt_c; sel_q = pt_d; sel_r = pt_b;
         end
      endcase
   end

   assign p_x = $signed(sel_p[PT_W-1:COORD_BITS]);
   assign p_y = $signed(sel_p[COORD_BITS-1:0]);
   assign q_x = $signed(sel_q[PT_W-1:COORD_BITS]);
   assign q_y = $signed(sel_q[COORD_BITS-1:0]);
   assign r_x = $signed(sel_r[PT_W-1:COORD_BITS]);
   assign r_y = $signed(sel_r[COORD_BITS-1:0]);

   always_comb begin
      if (step_ff[0]) begin
         da_in = DW'(q_y) - DW'(p_y);
         db_in = DW'(r_x) - DW'(p_x);
      end else begin
         da_in = DW'(q_x) - DW'(p_x);
         db_in = DW'(r_y) - DW'(p_y);
      end
   end

   assign prod_in = da_ff * db_ff;

   assign cmp_diff = EW'(first_ff) - EW'(prod_ff);
   assign cmp_neg  = cmp_diff[EW-1];
   assign cmp_pos  = !cmp_diff[EW-1] && (cmp_diff != '0);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 3'd1;
         if (step_ff == LastStep) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         step_ff   <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         step_ff   <= step_in;
         s1_vld_ff <= busy_ff;
         s2_vld_ff <= s1_vld_ff;
         done_ff   <= s2_vld_ff && (s2_step_ff == LastStep);
      end
   end

   always_ff @(posedge clock) begin
      s1_step_ff <= step_ff;
      da_ff      <= da_in;
      db_ff      <= db_in;
      s2_step_ff <= s1_step_ff;
      prod_ff    <= prod_in;
      if (s2_vld_ff) begin
         if (!s2_step_ff[0]) begin
            first_ff <= prod_ff;
         end else begin
            pos_ff[s2_step_ff[2:1]] <= cmp_pos;
            neg_ff[s2_step_ff[2:1]] <= cmp_neg;
         end
      end
   end

   assign unit_rsp.done = done_ff;
   assign unit_rsp.hit  = ((pos_ff[0] && neg_ff[1]) || (neg_ff[0] && pos_ff[1])) &&
                          ((pos_ff[2] && neg_ff[3]) || (neg_ff[2] && pos_ff[3]));

   a_done_follows_last: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(s2_vld_ff) && ($past(s2_step_ff) == LastStep))
      else $error("done without final product");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff && !s1_vld_ff && !s2_vld_ff)
      else $error("start while unit busy");

   a_busy_feeds_pipe: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> s1_vld_ff)
      else $error("issued step lost in pipeline");

endmodule

FILE: bench/polyline_crossing_trim_tb.sv
// testbench for polyline_crossing_trim: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module polyline_crossing_trim_tb
   import pct_pkg::*;
();

   localparam int MaxPoints = 64;
   localparam int CoordBits = 16;
   localparam int CntW = $clog2(MaxPoints + 1);
   localparam logic [1:0] OpIgnored = 2'd3;
   localparam int HoldCycles = 400;
   localparam int IdlePct = 23;

   typedef logic signed [CoordBits-1:0] coord_type;

   typedef enum int {SpreadFull, SpreadWide, SpreadGrid, SpreadExtreme} spread_type;

   typedef struct {
      logic [1:0] opcode;
      coord_type  x;
      coord_type  y;
   } trim_req_type;

   typedef struct {
      logic [CntW-1:0] left_keep;
      logic [CntW-1:0] right_keep;
      logic            crossed;
      logic            overflow;
   } trim_result_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   logic [1:0]      req_opcode = OpLeft;
   coord_type       req_coord_x = '0;
   coord_type       req_coord_y = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   logic [CntW-1:0] rsp_left_keep;
   logic [CntW-1:0] rsp_right_keep;
   logic            rsp_crossed;
   logic            rsp_overflow;

   trim_req_type    pending_requests[$];
   trim_result_type expected_trims[$];
   trim_req_type    next_req;
   trim_result_type want_trim;

   longint left_x[MaxPoints];
   longint left_y[MaxPoints];
   longint right_x[MaxPoints];
   longint right_y[MaxPoints];
   int     left_n = 0;
   int     right_n = 0;
   bit     points_dropped = 1'b0;

   int mismatches = 0;
   int queued_count = 0;
   int send_gap_pct = IdlePct;
   int stall_pct = IdlePct;
   bit hold_req = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;

   polyline_crossing_trim #(
      .MAX_POINTS(MaxPoints),
      .COORD_BITS(CoordBits)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_coord_x   (req_coord_x),
      .req_coord_y   (req_coord_y),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_left_keep (rsp_left_keep),
      .rsp_right_keep(rsp_right_keep),
      .rsp_crossed   (rsp_crossed),
      .rsp_overflow  (rsp_overflow)
   );

   always #2 clock = ~clock;

   function automatic int turn_sign(input longint ax, ay, bx, by, cx, cy);
      longint area;
      area = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
      return (area > 0) ? 1 : ((area < 0) ? -1 : 0);
   endfunction

   function automatic bit segments_cross(input int i, input int j);
      int d1, d2, d3, d4;
      d1 = turn_sign(left_x[i], left_y[i], left_x[i+1], left_y[i+1], right_x[j], right_y[j]);
      d2 = turn_sign(left_x[i], left_y[i], left_x[i+1], left_y[i+1],
                     right_x[j+1], right_y[j+1]);
      d3 = turn_sign(right_x[j], right_y[j], right_x[j+1], right_y[j+1], left_x[i], left_y[i]);
      d4 = turn_sign(right_x[j], right_y[j], right_x[j+1], right_y[j+1],
                     left_x[i+1], left_y[i+1]);
      return (d1 * d2 < 0) && (d3 * d4 < 0);
   endfunction

   task trim_step(input logic [1:0] op, input coord_type x, input coord_type y);
      trim_result_type res;
      int lk, rk;
      bit hit;
      case (op)
         OpLeft: begin
            if (left_n < MaxPoints) begin
               left_x[left_n] = x;
               left_y[left_n] = y;
               left_n++;
            end else begin
               points_dropped = 1'b1;
            end
         end
         OpRight: begin
            if (right_n < MaxPoints) begin
               right_x[right_n] = x;
               right_y[right_n] = y;
               right_n++;
            end else begin
               points_dropped = 1'b1;
            end
         end
         OpEval: begin
            lk = left_n;
            rk = right_n;
            hit = 1'b0;
            if (left_n >= 2 && right_n >= 2) begin
               for (int i = 0; i + 1 < left_n; i++) begin
                  for (int j = 0; j + 1 < right_n; j++) begin
                     if (segments_cross(i, j)) begin
                        hit = 1'b1;
                        if (i + 1 < lk) lk = i + 1;
                        if (j + 1 < rk) rk = j + 1;
                     end
                  end
               end
            end
            res.left_keep = CntW'(lk);
            res.right_keep = CntW'(rk);
            res.crossed = hit;
            res.overflow = points_dropped;
            expected_trims.insert(expected_trims.size(), res);
            left_n = 0;
            right_n = 0;
            points_dropped = 1'b0;
         end
         default: ;
      endcase
   endtask

   task report_mismatch(input string what);
      mismatches++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   function automatic coord_type pick_coord(input spread_type spread);
      logic [31:0] raw;
      int val;
      raw = $urandom();
      case (spread)
         SpreadWide: begin
            val = int'(raw % 4001) - 2000;
            return coord_type'(val);
         end
         SpreadGrid: begin
            val = int'(raw % 5) - 2;
            return coord_type'(val * 256);
         end
         SpreadExtreme: begin
            case (raw[2:0])
               3'd0: return 16'h8000;
               3'd1: return 16'h8001;
               3'd2: return 16'hff00;
               3'd3: return 16'hffff;
               3'd4: return 16'h0000;
               3'd5: return 16'h0001;
               3'd6: return 16'h0100;
               default: return 16'h7fff;
            endcase
         end
         default: return raw[CoordBits-1:0];
      endcase
   endfunction

   function automatic int pick_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return $urandom_range(0, 1);
      if (roll < 90) return $urandom_range(2, 8);
      return $urandom_range(9, 16);
   endfunction

   task queue_req(input logic [1:0] op, input coord_type x, input coord_type y);
      trim_req_type item;
      item.opcode = op;
      item.x = x;
      item.y = y;
      pending_requests.insert(pending_requests.size(), item);
      if (op != OpIgnored) queued_count++;
   endtask

   task queue_pair(input logic [1:0] op, input coord_type ax, ay, bx, by);
      queue_req(op, ax, ay);
      queue_req(op, bx, by);
   endtask

   task queue_polylines(input int nl, input int nr, input spread_type spread);
      int l, r;
      l = 0;
      r = 0;
      while (l < nl || r < nr) begin
         if ($urandom_range(0, 99) < 4)
            queue_req(OpIgnored, pick_coord(SpreadFull), pick_coord(SpreadFull));
         if (r >= nr || (l < nl && $urandom_range(1, nl + nr - l - r) <= nl - l)) begin
            queue_req(OpLeft, pick_coord(spread), pick_coord(spread));
            l++;
         end else begin
            queue_req(OpRight, pick_coord(spread), pick_coord(spread));
            r++;
         end
      end
      queue_req(OpEval, pick_coord(SpreadFull), pick_coord(SpreadFull));
   endtask

   task queue_random(input int target);
      while (queued_count < target)
         queue_polylines(pick_length(), pick_length(), spread_type'($urandom_range(0, 3)));
   endtask

   task wait_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_trims.size() != 0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_opcode <= OpLeft;
         req_coord_x <= '0;
         req_coord_y <= '0;
      end else begin
         if (req_valid && !req_stall) trim_step(req_opcode, req_coord_x, req_coord_y);
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               next_req = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_opcode <= next_req.opcode;
               req_coord_x <= next_req.x;
               req_coord_y <= next_req.y;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long hold-off lets the result register fill and back up the request side
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HoldCycles;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_trims.size() == 0) begin
            report_mismatch("result with no evaluate waiting");
         end else begin
            want_trim = expected_trims.pop_front();
            if (rsp_left_keep !== want_trim.left_keep)
               report_mismatch($sformatf("left_keep %0d, expected %0d",
                                         rsp_left_keep, want_trim.left_keep));
            if (rsp_right_keep !== want_trim.right_keep)
               report_mismatch($sformatf("right_keep %0d, expected %0d",
                                         rsp_right_keep, want_trim.right_keep));
            if (rsp_crossed !== want_trim.crossed)
               report_mismatch($sformatf("crossed %b, expected %b",
                                         rsp_crossed, want_trim.crossed));
            if (rsp_overflow !== want_trim.overflow)
               report_mismatch($sformatf("overflow %b, expected %b",
                                         rsp_overflow, want_trim.overflow));
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty polylines
      queue_req(OpEval, 16'h7fff, 16'h8000);
      // plain crossing
      queue_pair(OpLeft, -256, 0, 256, 0);
      queue_pair(OpRight, 0, -256, 0, 256);
      queue_req(OpEval, 0, 0);
      // endpoint touching the other segment
      queue_pair(OpLeft, 0, 0, 512, 0);
      queue_pair(OpRight, 256, 0, 256, 256);
      queue_req(OpEval, 16'hffff, 16'h0001);
      // collinear overlap
      queue_pair(OpLeft, 0, 0, 512, 0);
      queue_pair(OpRight, 256, 0, 768, 0);
      queue_req(OpEval, 0, 0);
      // full-range diagonals
      queue_pair(OpLeft, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
      queue_pair(OpRight, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
      queue_req(OpEval, 16'h5555, 16'haaaa);
      // single left point, ignored opcode
      queue_req(OpLeft, 16'h0100, 16'hff00);
      queue_pair(OpRight, -512, -512, 512, 512);
      queue_req(OpIgnored, 16'hffff, 16'hffff);
      queue_req(OpRight, -512, 512);
      queue_req(OpEval, 0, 0);
      wait_drained();

      queue_random(400);
      wait_drained();

      hold_req = 1'b1;
      repeat (8) queue_polylines($urandom_range(0, 3), $urandom_range(0, 3), SpreadWide);
      wait_drained();

      send_gap_pct = 0;
      stall_pct = 0;
      queue_random(700);
      wait_drained();
      send_gap_pct = IdlePct;
      stall_pct = IdlePct;

      // full polylines with dropped points
      queue_polylines(MaxPoints + 2, MaxPoints + 1, SpreadWide);
      queue_polylines(3, MaxPoints + 6, SpreadFull);
      wait_drained();

      queue_random(1000);
      wait_drained();
      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
